FILE: sv/drkr_pkg.sv
// ----------------------------------------------------------------------------
// drkr_pkg: shared types and constants of the dual-role key remapper
// Event codes, beat payload structs and the plan that the front hands
// to the back through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package drkr_pkg;

   // Event types.
   localparam logic [4:0] T_SYN = 5'd0;
   localparam logic [4:0] T_KEY = 5'd1;
   localparam logic [4:0] T_MSC = 5'd4;

   // Event codes.
   localparam logic [9:0] C_SCAN  = 10'd4;
   localparam logic [9:0] K_ESC   = 10'd1;
   localparam logic [9:0] K_TAB   = 10'd15;
   localparam logic [9:0] K_CTRL  = 10'd29;
   localparam logic [9:0] K_SHIFT = 10'd42;
   localparam logic [9:0] K_ALT   = 10'd56;
   localparam logic [9:0] K_CAPS  = 10'd58;
   localparam logic [9:0] K_META  = 10'd125;

   // Key event values.
   localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
   localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
   localparam logic signed [31:0] VAL_REPEAT  = 32'sd2;

   typedef struct packed {
      logic [4:0]         ev_type;
      logic [9:0]         ev_code;
      logic signed [31:0] ev_value;
   } req_type;

   typedef struct packed {
      logic [4:0]         out_type;
      logic [9:0]         out_code;
      logic signed [31:0] out_value;
      logic               pause_after;
      logic               last;
   } rsp_type;

   // What closes the sequence of beats for one item.
   typedef enum logic [2:0] {
      TAIL_NONE,
      TAIL_PASS,
      TAIL_TAP_TAB,
      TAIL_TAP_ESC,
      TAIL_TAB_UP,
      TAIL_CTRL_UP
   } tail_type;

   // Group of beats the back sequencer is working through.
   typedef enum logic [1:0] {
      PH_TAB,
      PH_CAPS,
      PH_TAIL
   } phase_type;

   // One classified item. tab_dn adds Alt, Shift, Meta presses and a sync;
   // caps_dn adds a Ctrl press and a sync; the tail follows them.
   typedef struct packed {
      logic               tab_dn;
      logic               caps_dn;
      tail_type           tail;
      logic [4:0]         ev_type;
      logic [9:0]         ev_code;
      logic signed [31:0] ev_value;
   } plan_type;

endpackage

`default_nettype wire

FILE: sv/drkr_front.sv
// ----------------------------------------------------------------------------
// drkr_front: event classifier
// Holds the modifier state and turns each accepted event into a plan.
// ----------------------------------------------------------------------------
`default_nettype none

module drkr_front
   import drkr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire req_type  req_data,
   input  wire logic     q_full,
   output logic          q_push,
   output plan_type      q_plan
);

   logic alt_held_ff, alt_held_in;
   logic tab_held_ff, tab_held_in;
   logic tab_mod_ff, tab_mod_in;
   logic caps_held_ff, caps_held_in;
   logic caps_mod_ff, caps_mod_in;
   logic accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic press, release_k, repeat_k, is_key, done;
      press     = (req_data.ev_value == VAL_PRESS);
      release_k = (req_data.ev_value == VAL_RELEASE);
      repeat_k  = (req_data.ev_value == VAL_REPEAT);
      is_key    = (req_data.ev_type == T_KEY);
      done      = 1'b0;

      alt_held_in  = alt_held_ff;
      tab_held_in  = tab_held_ff;
      tab_mod_in   = tab_mod_ff;
      caps_held_in = caps_held_ff;
      caps_mod_in  = caps_mod_ff;

      q_plan.tab_dn   = 1'b0;
      q_plan.caps_dn  = 1'b0;
      q_plan.tail     = TAIL_NONE;
      q_plan.ev_type  = req_data.ev_type;
      q_plan.ev_code  = req_data.ev_code;
      q_plan.ev_value = req_data.ev_value;

      if (req_data.ev_type == T_MSC && req_data.ev_code == C_SCAN) begin
         done = 1'b1;
      end else if (!is_key) begin
         q_plan.tail = TAIL_PASS;
         done = 1'b1;
      end

      if (!done) begin
         if (req_data.ev_code == K_ALT && press) begin
            alt_held_in = 1'b1;
         end else if (req_data.ev_code == K_ALT && release_k) begin
            alt_held_in = 1'b0;
         end

         if (tab_held_ff) begin
            if (req_data.ev_code == K_TAB && (press || repeat_k)) begin
               done = 1'b1;
            end else if (req_data.ev_code == K_TAB && release_k) begin
               tab_held_in = 1'b0;
               tab_mod_in  = 1'b0;
               q_plan.tail = tab_mod_ff ? TAIL_TAB_UP : TAIL_TAP_TAB;
               done = 1'b1;
            end else if (!release_k) begin
               tab_mod_in    = 1'b1;
               q_plan.tab_dn = 1'b1;
            end
         end else if (req_data.ev_code == K_TAB && press && !alt_held_in) begin
            tab_held_in = 1'b1;
            done = 1'b1;
         end
      end

      if (!done) begin
         if (caps_held_ff) begin
            if (req_data.ev_code == K_CAPS && (press || repeat_k)) begin
               done = 1'b1;
            end else if (req_data.ev_code == K_CAPS && release_k) begin
               caps_held_in = 1'b0;
               caps_mod_in  = 1'b0;
               q_plan.tail  = caps_mod_ff ? TAIL_CTRL_UP : TAIL_TAP_ESC;
               done = 1'b1;
            end else if (!release_k) begin
               caps_mod_in    = 1'b1;
               q_plan.caps_dn = 1'b1;
            end
         end else if (req_data.ev_code == K_CAPS && press) begin
            if (!alt_held_in) begin
               caps_held_in = 1'b1;
            end
            done = 1'b1;
         end else if (req_data.ev_code == K_CAPS && release_k) begin
            q_plan.tail = TAIL_TAP_ESC;
            done = 1'b1;
         end
      end

      if (!done) begin
         q_plan.tail = TAIL_PASS;
         if (req_data.ev_code == K_ESC) begin
            q_plan.ev_code = K_CAPS;
         end
      end

      // Items that produce no beat are consumed here and never queued.
      q_push = accept && (q_plan.tab_dn || q_plan.caps_dn || q_plan.tail != TAIL_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_held_ff  <= 1'b0;
         tab_held_ff  <= 1'b0;
         tab_mod_ff   <= 1'b0;
         caps_held_ff <= 1'b0;
         caps_mod_ff  <= 1'b0;
      end else if (accept) begin
         alt_held_ff  <= alt_held_in;
         tab_held_ff  <= tab_held_in;
         tab_mod_ff   <= tab_mod_in;
         caps_held_ff <= caps_held_in;
         caps_mod_ff  <= caps_mod_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/drkr_queue.sv
// ----------------------------------------------------------------------------
// drkr_queue: plan queue
// Shifting queue between front and back; the head always sits in entry 0.
// ----------------------------------------------------------------------------
`default_nettype none

module drkr_queue
   import drkr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire plan_type push_plan,
   output logic          full,
   output logic          head_valid,
   output plan_type      head_plan,
   input  wire logic     pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   plan_type           entries_ff [DEPTH];
   plan_type           entries_in [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   wr_cnt;
   logic [PTR_W-1:0]   wr_idx;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_plan  = entries_ff[0];

   always_comb begin
      wr_cnt = count_ff - CNT_W'(pop);
      wr_idx = wr_cnt[PTR_W-1:0];
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && i < DEPTH - 1) begin
            entries_in[i] = entries_ff[(i + 1) % DEPTH];
         end else begin
            entries_in[i] = entries_ff[i];
         end
      end
      if (push) begin
         entries_in[wr_idx] = push_plan;
      end
      count_in = wr_cnt + CNT_W'(push);
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/drkr_back.sv
// ----------------------------------------------------------------------------
// drkr_back: beat sequencer
// Walks a plan into the output register, one result beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module drkr_back
   import drkr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_valid,
   input  wire plan_type q_plan,
   output logic          q_pop,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output rsp_type       rsp_data
);

   logic      busy_ff, busy_in;
   plan_type  plan_ff, plan_in;
   phase_type phase_ff, phase_in;
   logic [1:0] sub_ff, sub_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   rsp_type   slot;
   logic      slot_end;
   logic      has_next;
   phase_type next_phase;
   phase_type first_phase;
   logic      step, finish, load;
   logic [9:0] tap_code;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Beat selected by the current phase and position.
   always_comb begin
      slot.out_type    = T_KEY;
      slot.out_code    = K_ALT;
      slot.out_value   = VAL_PRESS;
      slot.pause_after = 1'b0;
      slot.last        = 1'b0;
      slot_end         = 1'b0;
      tap_code = (plan_ff.tail == TAIL_TAP_TAB) ? K_TAB : K_ESC;

      case (phase_ff)
         PH_TAB: begin
            case (sub_ff)
               2'd0: slot.out_code = K_ALT;
               2'd1: slot.out_code = K_SHIFT;
               2'd2: slot.out_code = K_META;
               default: begin
                  slot.out_type    = T_SYN;
                  slot.out_code    = '0;
                  slot.out_value   = VAL_RELEASE;
                  slot.pause_after = 1'b1;
                  slot_end         = 1'b1;
               end
            endcase
         end
         PH_CAPS: begin
            if (sub_ff == 2'd0) begin
               slot.out_code = K_CTRL;
            end else begin
               slot.out_type    = T_SYN;
               slot.out_code    = '0;
               slot.out_value   = VAL_RELEASE;
               slot.pause_after = 1'b1;
               slot_end         = 1'b1;
            end
         end
         default: begin
            case (plan_ff.tail)
               TAIL_TAP_TAB, TAIL_TAP_ESC: begin
                  slot.out_code = tap_code;
                  if (sub_ff == 2'd1) begin
                     slot.out_type    = T_SYN;
                     slot.out_code    = '0;
                     slot.out_value   = VAL_RELEASE;
                     slot.pause_after = 1'b1;
                  end else if (sub_ff != 2'd0) begin
                     slot.out_value = VAL_RELEASE;
                     slot_end       = 1'b1;
                  end
               end
               TAIL_TAB_UP: begin
                  slot.out_value = VAL_RELEASE;
                  if (sub_ff == 2'd0) begin
                     slot.out_code = K_ALT;
                  end else if (sub_ff == 2'd1) begin
                     slot.out_code = K_SHIFT;
                  end else begin
                     slot.out_code = K_META;
                     slot_end      = 1'b1;
                  end
               end
               TAIL_CTRL_UP: begin
                  slot.out_code  = K_CTRL;
                  slot.out_value = VAL_RELEASE;
                  slot_end       = 1'b1;
               end
               default: begin
                  slot.out_type  = plan_ff.ev_type;
                  slot.out_code  = plan_ff.ev_code;
                  slot.out_value = plan_ff.ev_value;
                  slot_end       = 1'b1;
               end
            endcase
         end
      endcase

      case (phase_ff)
         PH_TAB: begin
            if (plan_ff.caps_dn) begin
               next_phase = PH_CAPS;
               has_next   = 1'b1;
            end else begin
               next_phase = PH_TAIL;
               has_next   = (plan_ff.tail != TAIL_NONE);
            end
         end
         PH_CAPS: begin
            next_phase = PH_TAIL;
            has_next   = (plan_ff.tail != TAIL_NONE);
         end
         default: begin
            next_phase = PH_TAIL;
            has_next   = 1'b0;
         end
      endcase

      slot.last = slot_end && !has_next;

      if (q_plan.tab_dn) begin
         first_phase = PH_TAB;
      end else if (q_plan.caps_dn) begin
         first_phase = PH_CAPS;
      end else begin
         first_phase = PH_TAIL;
      end
   end

   // Sequencer control and output register.
   always_comb begin
      step   = busy_ff && (!rsp_valid_ff || rsp_ready);
      finish = step && slot.last;
      load   = q_valid && (!busy_ff || finish);
      q_pop  = load;

      busy_in  = busy_ff;
      plan_in  = plan_ff;
      phase_in = phase_ff;
      sub_in   = sub_ff;

      if (load) begin
         busy_in  = 1'b1;
         plan_in  = q_plan;
         phase_in = first_phase;
         sub_in   = 2'd0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (step) begin
         if (slot_end) begin
            phase_in = next_phase;
            sub_in   = 2'd0;
         end else begin
            sub_in = sub_ff + 2'd1;
         end
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = slot;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_TAB;
         sub_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff     <= plan_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: sv/dual_role_key_remapper_top.sv
// ----------------------------------------------------------------------------
// dual_role_key_remapper_top: tap/hold dual-role key remapper
// Turns a stream of keyboard events into a stream of remapped events.
// ----------------------------------------------------------------------------
// Each request beat is one keyboard event (type, code, value); each response
// beat is one emitted event plus a pause flag and a last flag, and one
// request yields zero to seven response beats. Tab tapped alone gives Tab and
// held under another key gives left Alt + Shift + Meta; CapsLock tapped alone
// gives Esc and held under another key gives left Ctrl; plain Esc is sent as
// CapsLock; scan-code events are dropped and non-key events pass through.
// The pause flag, set only on the sync beat of a synthesized sequence, asks
// the consumer for a 20 ms (20000 us) gap after that beat. Timing: the front
// classifies and accepts one request per cycle as long as the plan queue
// (QUEUE_DEPTH entries) has room; when the back is free, an accepted event's
// plan passes through the queue and the back's plan register before its first
// beat is registered at the output. The back sequencer emits one response
// beat per cycle while the consumer takes them, and a request yields one beat
// for a pass-through, up to seven when both dual-role keys turn into modifiers
// at once, and none when dropped or swallowed, which the front absorbs in its
// accept cycle. That one-beat-per-cycle sequencer sets the sustained rate.
`default_nettype none

module dual_role_key_remapper_top
   import drkr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // Classified plans travel from the front to the back through the queue.
   logic     q_push;
   plan_type q_push_plan;
   logic     q_full;
   logic     q_head_valid;
   plan_type q_head_plan;
   logic     q_pop;

   // The front owns the modifier state and decides the beats for an event.
   drkr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_plan    (q_push_plan)
   );

   // The queue lets the front keep accepting while the back is stalled.
   drkr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_plan  (q_push_plan),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_plan  (q_head_plan),
      .pop        (q_pop)
   );

   // The back expands each plan into response beats through a registered output.
   drkr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_head_valid),
      .q_plan    (q_head_plan),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: tb/dual_role_key_remapper_top_tb.sv
// ----------------------------------------------------------------------------
// dual_role_key_remapper_top_tb: self-checking bench for the key remapper
// Drives keyboard events through the request channel, predicts the remapped
// events with a cycle-free behavioral copy of the tap/hold rules, and checks
// every response beat in order against that prediction.
// ----------------------------------------------------------------------------

module dual_role_key_remapper_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import drkr_pkg::*;

   localparam int CLK_PERIOD     = 10;
   localparam int RESET_CYCLES   = 5;
   // Cycles without any handshake before the run is declared hung. A correct
   // run never comes close: the longest quiet stretch is a receiver stall
   // at 80 percent idling plus the short settle after each drain.
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet cycles after the last expected beat, so that a dropped event still
   // in the plan queue has time to show up as a stray beat.
   localparam int SETTLE_CYCLES  = 16;
   localparam int PHASE_ITEMS    = 128;

   // An ordinary letter key used to form chords with the dual-role keys.
   localparam logic [9:0] KEY_A = 10'd30;

   // -------------------------------------------------------------------------
   // Scoreboard: owns the predicted key state and the queue of remapped
   // events still owed by the block.
   // -------------------------------------------------------------------------
   class key_event_scoreboard;
      localparam int MAX_REPORTS = 10;

      rsp_type remapped_q[$];
      rsp_type step_q[$];
      int      mismatches;
      int      beats_checked;

      // Predicted modifier state, mirroring what the block keeps internally.
      bit alt_pressed;
      bit tab_pressed;
      bit tab_chorded;
      bit caps_pressed;
      bit caps_chorded;

      function new();
         mismatches    = 0;
         beats_checked = 0;
         alt_pressed   = 1'b0;
         tab_pressed   = 1'b0;
         tab_chorded   = 1'b0;
         caps_pressed  = 1'b0;
         caps_chorded  = 1'b0;
      endfunction

      function int pending();
         return remapped_q.size();
      endfunction

      function void emit_event(logic [4:0] t, logic [9:0] c, logic signed [31:0] v,
                               logic pause);
         rsp_type r;
         r.out_type    = t;
         r.out_code    = c;
         r.out_value   = v;
         r.pause_after = pause;
         r.last        = 1'b0;
         step_q.push_back(r);
      endfunction

      // A synthesized tap: press, sync with pause, release.
      function void emit_tap(logic [9:0] c);
         emit_event(T_KEY, c, VAL_PRESS, 1'b0);
         emit_event(T_SYN, 10'd0, 32'sd0, 1'b1);
         emit_event(T_KEY, c, VAL_RELEASE, 1'b0);
      endfunction

      function void remap(req_type item);
         logic [4:0]         t;
         logic [9:0]         c;
         logic signed [31:0] v;
         bit                 is_press;
         bit                 is_release;
         bit                 is_repeat;
         t          = item.ev_type;
         c          = item.ev_code;
         v          = item.ev_value;
         is_press   = (v == VAL_PRESS);
         is_release = (v == VAL_RELEASE);
         is_repeat  = (v == VAL_REPEAT);

         if (t == T_MSC && c == C_SCAN) return;
         if (t != T_KEY) begin
            emit_event(t, c, v, 1'b0);
            return;
         end

         if (c == K_ALT && is_press) alt_pressed = 1'b1;
         else if (c == K_ALT && is_release) alt_pressed = 1'b0;

         if (tab_pressed) begin
            if (c == K_TAB && (is_press || is_repeat)) return;
            if (c == K_TAB && is_release) begin
               tab_pressed = 1'b0;
               if (tab_chorded) begin
                  tab_chorded = 1'b0;
                  emit_event(T_KEY, K_ALT, VAL_RELEASE, 1'b0);
                  emit_event(T_KEY, K_SHIFT, VAL_RELEASE, 1'b0);
                  emit_event(T_KEY, K_META, VAL_RELEASE, 1'b0);
               end else begin
                  emit_tap(K_TAB);
               end
               return;
            end
            // Any nonzero value, odd ones included, turns Tab into modifiers.
            if (!is_release) begin
               tab_chorded = 1'b1;
               emit_event(T_KEY, K_ALT, VAL_PRESS, 1'b0);
               emit_event(T_KEY, K_SHIFT, VAL_PRESS, 1'b0);
               emit_event(T_KEY, K_META, VAL_PRESS, 1'b0);
               emit_event(T_SYN, 10'd0, 32'sd0, 1'b1);
            end
         end else if (c == K_TAB && is_press && !alt_pressed) begin
            tab_pressed = 1'b1;
            return;
         end

         if (caps_pressed) begin
            if (c == K_CAPS && (is_press || is_repeat)) return;
            if (c == K_CAPS && is_release) begin
               caps_pressed = 1'b0;
               if (caps_chorded) begin
                  caps_chorded = 1'b0;
                  emit_event(T_KEY, K_CTRL, VAL_RELEASE, 1'b0);
               end else begin
                  emit_tap(K_ESC);
               end
               return;
            end
            if (!is_release) begin
               caps_chorded = 1'b1;
               emit_event(T_KEY, K_CTRL, VAL_PRESS, 1'b0);
               emit_event(T_SYN, 10'd0, 32'sd0, 1'b1);
            end
         end else if (c == K_CAPS && is_press) begin
            // With Alt held the press is swallowed and CapsLock stays plain.
            if (!alt_pressed) caps_pressed = 1'b1;
            return;
         end else if (c == K_CAPS && is_release) begin
            emit_tap(K_ESC);
            return;
         end

         if (c == K_ESC) c = K_CAPS;
         emit_event(t, c, v, 1'b0);
      endfunction

      // Records one accepted request and returns how many beats it owes.
      function int note_request(req_type item);
         step_q.delete();
         remap(item);
         if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
         foreach (step_q[i]) remapped_q.push_back(step_q[i]);
         return step_q.size();
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%s at %0t: expected type %0d code %0d value %0d pause %0b last %0b,",
                     what, $realtime, want.out_type, want.out_code, want.out_value,
                     want.pause_after, want.last);
            $display("   got type %0d code %0d value %0d pause %0b last %0b",
                     got.out_type, got.out_code, got.out_value, got.pause_after,
                     got.last);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         beats_checked++;
         if (remapped_q.size() == 0) begin
            report("Unexpected beat", '0, got);
            return;
         end
         want = remapped_q.pop_front();
         if (got.out_type !== want.out_type || got.out_code !== want.out_code ||
             got.out_value !== want.out_value || got.pause_after !== want.pause_after ||
             got.last !== want.last) begin
            report("Beat mismatch", want, got);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and the device under test.
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Percent of cycles in which each side holds off.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Every accepted request advances the stimulus; the requests that produced
   // at least one beat are counted apart for the summary.
   int items_effective = 0;
   int items_sent      = 0;

   key_event_scoreboard board;

   always #(CLK_PERIOD / 2) clock = ~clock;

   dual_role_key_remapper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Request side. All drives are nonblocking right after a rising edge, and
   // the handshake is read in the same place, which sees the values that the
   // edge itself sampled. Valid is raised without looking at ready and holds
   // its payload until the beat is taken.
   // -------------------------------------------------------------------------
   function automatic req_type make_event(logic [4:0] t, logic [9:0] c,
                                          logic signed [31:0] v);
      req_type item;
      item.ev_type  = t;
      item.ev_code  = c;
      item.ev_value = v;
      return item;
   endfunction

   task automatic send_event(input req_type item);
      // Random hold-off before the beat. Valid drops only when a gap is taken,
      // so back-to-back beats keep it high with a single assignment per step.
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      items_sent++;
      if (board.note_request(item) > 0) items_effective++;
   endtask

   task automatic send_key(input logic [9:0] code, input logic signed [31:0] value);
      send_event(make_event(T_KEY, code, value));
   endtask

   // Stop sending and wait until the block owes nothing, then a little longer
   // to catch stray beats from events that should have been dropped.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Value of a chord key: mostly a press, sometimes a repeat, and now and
   // then an arbitrary random value.
   function automatic logic signed [31:0] chord_value();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return VAL_REPEAT;
         default: return VAL_PRESS;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Directed events: the main paths through the tap/hold logic, plus the
   // extremes of the type, code and value fields.
   // -------------------------------------------------------------------------
   task automatic run_directed();
      send_event(make_event(T_SYN, 10'd0, 32'sd0));
      // Scan codes are dropped outright.
      send_event(make_event(T_MSC, C_SCAN, 32'sd30));
      send_event(make_event(5'd31, 10'd1023, 32'sh7fff_ffff));
      // An ordinary key with a value that is no press, release or repeat.
      send_key(10'd0, 32'sh8000_0000);
      // Plain Esc comes out as CapsLock.
      send_key(K_ESC, VAL_PRESS);
      send_key(K_ESC, VAL_RELEASE);
      // Tab tapped alone, with a repeat that must be swallowed.
      send_key(K_TAB, VAL_PRESS);
      send_key(K_TAB, VAL_REPEAT);
      send_key(K_TAB, VAL_RELEASE);
      // Tab held under a letter turns into Alt + Shift + Meta.
      send_key(K_TAB, VAL_PRESS);
      send_key(KEY_A, VAL_PRESS);
      send_key(KEY_A, VAL_RELEASE);
      send_key(K_TAB, VAL_RELEASE);
      // CapsLock tapped alone gives Esc.
      send_key(K_CAPS, VAL_PRESS);
      send_key(K_CAPS, VAL_RELEASE);
      // Both dual-role keys held, then a key with an odd value: this is the
      // seven-beat case (three modifiers and a sync, Ctrl and a sync, the key).
      send_key(K_CAPS, VAL_PRESS);
      send_key(K_TAB, VAL_PRESS);
      send_key(KEY_A, 32'sh8000_0000);
      send_key(KEY_A, VAL_RELEASE);
      send_key(K_CAPS, VAL_RELEASE);
      send_key(K_TAB, VAL_RELEASE);
      // With left Alt held, CapsLock press is swallowed and its release gives a
      // tap of Esc; Tab passes through as a plain key, release included.
      send_key(K_ALT, VAL_PRESS);
      send_key(K_CAPS, VAL_PRESS);
      send_key(K_CAPS, VAL_RELEASE);
      send_key(K_TAB, VAL_PRESS);
      send_key(K_TAB, VAL_RELEASE);
      send_key(K_ALT, VAL_RELEASE);
   endtask

   // -------------------------------------------------------------------------
   // Random stimulus: mostly realistic tap and chord sequences with random
   // keys and values, with some noise and some broken sequences mixed in.
   // -------------------------------------------------------------------------
   task automatic play_pattern();
      logic [9:0] other;
      int         pick;
      other = 10'($urandom_range(0, 1023));
      pick  = $urandom_range(0, 19);
      if (pick < 3) begin
         send_key(K_TAB, VAL_PRESS);
         repeat ($urandom_range(0, 2)) send_key(K_TAB, VAL_REPEAT);
         send_key(K_TAB, VAL_RELEASE);
      end else if (pick < 6) begin
         send_key(K_TAB, VAL_PRESS);
         send_key(other, chord_value());
         send_key(other, VAL_RELEASE);
         send_key(K_TAB, VAL_RELEASE);
      end else if (pick < 8) begin
         send_key(K_CAPS, VAL_PRESS);
         repeat ($urandom_range(0, 2)) send_key(K_CAPS, VAL_REPEAT);
         send_key(K_CAPS, VAL_RELEASE);
      end else if (pick < 11) begin
         send_key(K_CAPS, VAL_PRESS);
         send_key(other, chord_value());
         send_key(other, VAL_RELEASE);
         send_key(K_CAPS, VAL_RELEASE);
      end else if (pick < 13) begin
         // Both dual-role keys at once, released in either order.
         send_key(K_CAPS, VAL_PRESS);
         send_key(K_TAB, VAL_PRESS);
         send_key(other, chord_value());
         send_key(other, VAL_RELEASE);
         if ($urandom_range(0, 1)) begin
            send_key(K_TAB, VAL_RELEASE);
            send_key(K_CAPS, VAL_RELEASE);
         end else begin
            send_key(K_CAPS, VAL_RELEASE);
            send_key(K_TAB, VAL_RELEASE);
         end
      end else if (pick < 14) begin
         // Left Alt around a dual-role key; sometimes Alt lets go first.
         send_key(K_ALT, VAL_PRESS);
         if ($urandom_range(0, 1)) begin
            send_key(K_TAB, VAL_PRESS);
            if ($urandom_range(0, 1)) send_key(K_ALT, VAL_RELEASE);
            send_key(K_TAB, VAL_RELEASE);
         end else begin
            send_key(K_CAPS, VAL_PRESS);
            if ($urandom_range(0, 1)) send_key(K_ALT, VAL_RELEASE);
            send_key(K_CAPS, VAL_RELEASE);
         end
         send_key(K_ALT, VAL_RELEASE);
      end else if (pick < 15) begin
         send_key(K_ESC, VAL_PRESS);
         send_key(K_ESC, VAL_RELEASE);
      end else if (pick < 16) begin
         send_event(make_event(T_MSC, C_SCAN, $urandom()));
         send_event(make_event(T_SYN, 10'd0, 32'sd0));
      end else if (pick < 18) begin
         // Noise: any type, any code, any value, keys included.
         if ($urandom_range(0, 1))
            send_event(make_event(5'($urandom_range(0, 31)), other, $urandom()));
         else
            send_key(other, $urandom());
      end else begin
         // Broken sequences: lone releases, lone presses, stray repeats.
         case ($urandom_range(0, 4))
            0: send_key(K_TAB, VAL_RELEASE);
            1: send_key(K_CAPS, VAL_RELEASE);
            2: send_key(K_TAB, VAL_PRESS);
            3: send_key(K_CAPS, VAL_PRESS);
            default: send_key(K_CAPS, VAL_REPEAT);
         endcase
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input int count);
      int goal;
      bit drained;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      goal          = items_sent + count;
      drained       = 1'b0;
      while (items_sent < goal) begin
         play_pattern();
         // Once per phase, halfway through, the sender holds off until the
         // block has delivered everything it owes.
         if (!drained && items_sent >= goal - count / 2) begin
            wait_for_drain();
            drained = 1'b1;
         end
      end
      wait_for_drain();
   endtask

   // -------------------------------------------------------------------------
   // Response side: take a beat when valid and ready met at the edge, then
   // pick ready for the next cycle according to the current idle rate.
   // -------------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
            board.check_response(rsp_data);
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: a run in which no beat moves on either channel for too long
   // is hung.
   // -------------------------------------------------------------------------
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (reset) @(posedge clock);
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no beat moved for %0d cycles, %0d beats still owed",
               WATCHDOG_LIMIT, board.pending());
      $display("FAIL dual_role_key_remapper_top");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence: reset, directed events, then three random phases with
   // the receiver slow, the sender slow, and finally neither holding off.
   // -------------------------------------------------------------------------
   initial begin
      board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 10;
      recv_idle_pct = 80;
      run_directed();
      wait_for_drain();

      run_random_phase(10, 80, PHASE_ITEMS);
      run_random_phase(80, 10, PHASE_ITEMS);
      run_random_phase(0, 0, PHASE_ITEMS);

      $display("Run covered %0d request beats (%0d with output) and %0d response beats,",
               items_sent, items_effective, board.beats_checked);
      $display("   over taps, holds and chords of Tab and CapsLock, Alt, Esc and noise.");
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS dual_role_key_remapper_top");
      end else begin
         $display("%0d mismatching beats, %0d beats never delivered",
                  board.mismatches, board.pending());
         $display("FAIL dual_role_key_remapper_top");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/drkr_pkg.sv
sv/drkr_front.sv
sv/drkr_queue.sv
sv/drkr_back.sv
sv/dual_role_key_remapper_top.sv
tb/dual_role_key_remapper_top_tb.sv
